/* src/lru_kvc_pkg.sv */
// Shared constants for the LRU key-value cache: store depth, index widths,
// command codes and configuration register map. No dependencies.
package lru_kvc_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    localparam int CAP_W  = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

endpackage

/* src/lru_key_value_cache_unit.sv */
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lru_kvc_pkg for depth, widths, command codes and register map.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start / busy         | command, key, value
//  result    | done (strobe)        | found, read_value, evicted, evicted_key
//  config    | APB psel/penable     | paddr, pwdata, prdata (capacity)
//
// An item is taken into the input register on the cycle start is seen (busy is
// always low), looked up against all entries in parallel in the next cycle, and
// its result is on the outputs with done high in the cycle after that; one item
// per cycle is sustained. The store updates at the same edge as the result
// register, so a following item sees it. Reset empties the store and sets
// capacity to 16. The receiver cannot stall the result.
module lru_key_value_cache_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  command,
    input  logic signed [lru_kvc_pkg::KEY_W-1:0]  key,
    input  logic signed [lru_kvc_pkg::VAL_W-1:0]  value,

    output logic                                  done,
    output logic                                  found,
    output logic signed [lru_kvc_pkg::VAL_W-1:0]  read_value,
    output logic                                  evicted,
    output logic signed [lru_kvc_pkg::KEY_W-1:0]  evicted_key,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lru_kvc_pkg::ADDR_W-1:0]        paddr,
    input  logic [lru_kvc_pkg::DATA_W-1:0]        pwdata,
    output logic [lru_kvc_pkg::DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int D  = lru_kvc_pkg::DEPTH;
    localparam int IW = lru_kvc_pkg::IDX_W;
    localparam int RW = lru_kvc_pkg::RANK_W;
    localparam int CW = lru_kvc_pkg::CNT_W;

    // configuration
    logic [lru_kvc_pkg::CAP_W-1:0] cap_reg;
    logic                          cfg_write;

    // input register
    logic                                 in_valid_reg;
    logic                                 in_cmd_reg;
    logic signed [lru_kvc_pkg::KEY_W-1:0] in_key_reg;
    logic signed [lru_kvc_pkg::VAL_W-1:0] in_val_reg;

    // store
    logic signed [lru_kvc_pkg::KEY_W-1:0] key_reg   [D];
    logic signed [lru_kvc_pkg::VAL_W-1:0] val_reg   [D];
    logic        [D-1:0]                  valid_reg;
    logic        [RW-1:0]                 rank_reg  [D];
    logic        [CW-1:0]                 count_reg;

    logic        [D-1:0]                  valid_next;
    logic        [RW-1:0]                 rank_next [D];
    logic        [CW-1:0]                 count_next;

    // result register
    logic                                 done_reg;
    logic                                 found_reg;
    logic signed [lru_kvc_pkg::VAL_W-1:0] read_value_reg;
    logic                                 evicted_reg;
    logic signed [lru_kvc_pkg::KEY_W-1:0] evicted_key_reg;

    logic                                 found_next;
    logic signed [lru_kvc_pkg::VAL_W-1:0] read_value_next;
    logic                                 evicted_next;
    logic signed [lru_kvc_pkg::KEY_W-1:0] evicted_key_next;

    // lookup and write control
    logic [CW-1:0] cap_eff;
    logic [D-1:0]  match;
    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] lru_idx;
    logic [IW-1:0] free_idx;
    logic [RW-1:0] lru_rank;
    logic [RW-1:0] hit_rank;
    logic          do_evict;
    logic          do_fill;
    logic          do_touch;
    logic [IW-1:0] fill_idx;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[lru_kvc_pkg::ADDR_W-1:2] == lru_kvc_pkg::REG_CAPACITY);
    assign prdata    = (paddr[lru_kvc_pkg::ADDR_W-1:2] == lru_kvc_pkg::REG_CAPACITY)
                       ? lru_kvc_pkg::DATA_W'(cap_reg) : '0;

    assign done        = done_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    always_comb
    begin
        // clamp capacity into 1..DEPTH
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(cap_reg) > 32'(D))
        begin
            cap_eff = CW'(D);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end

        // ranks of valid entries form 0..count-1, so the LRU entry is unique
        lru_rank = RW'(count_reg - CW'(1));

        hit_idx  = '0;
        lru_idx  = '0;
        free_idx = '0;
        for (int i = D - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == in_key_reg);
            if (match[i])
            begin
                hit_idx = IW'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == lru_rank))
            begin
                lru_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
        hit      = |match;
        hit_rank = rank_reg[hit_idx];

        do_touch = in_valid_reg && hit;
        do_fill  = in_valid_reg && !hit && (in_cmd_reg == lru_kvc_pkg::CMD_PUT);
        do_evict = do_fill && (count_reg >= cap_eff);
        fill_idx = do_evict ? lru_idx : free_idx;

        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < D; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_touch)
            begin
                if (IW'(i) == hit_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            else if (do_fill)
            begin
                if (IW'(i) == fill_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
        end
        if (do_fill)
        begin
            valid_next[fill_idx] = 1'b1;
            if (!do_evict)
            begin
                count_next = count_reg + CW'(1);
            end
        end

        found_next       = hit;
        evicted_next     = do_evict;
        evicted_key_next = do_evict ? key_reg[lru_idx] : '0;
        if (in_cmd_reg == lru_kvc_pkg::CMD_PUT)
        begin
            read_value_next = '0;
        end
        else if (hit)
        begin
            read_value_next = val_reg[hit_idx];
        end
        else
        begin
            read_value_next = lru_kvc_pkg::MISS_VALUE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= lru_kvc_pkg::CAP_RESET;
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
            count_reg    <= '0;
            for (int i = 0; i < D; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= pwdata[lru_kvc_pkg::CAP_W-1:0];
            end
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            for (int i = 0; i < D; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // payload: input transfer, store contents and result fields
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_cmd_reg <= command;
            in_key_reg <= key;
            in_val_reg <= value;
        end
        if (do_fill)
        begin
            key_reg[fill_idx] <= in_key_reg;
            val_reg[fill_idx] <= in_val_reg;
        end
        else if (do_touch && (in_cmd_reg == lru_kvc_pkg::CMD_PUT))
        begin
            val_reg[hit_idx] <= in_val_reg;
        end
        if (in_valid_reg)
        begin
            found_reg       <= found_next;
            read_value_reg  <= read_value_next;
            evicted_reg     <= evicted_next;
            evicted_key_reg <= evicted_key_next;
        end
    end

endmodule
